>>> rtl/pehd_pkg.sv
// Package for the pin edge and hold detector.
// Holds the event codes, the configuration and result structs and the
// register map. No dependencies.
package pehd_pkg;

  localparam int unsigned TimeWidth = 32;
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  typedef enum logic [1:0] {
    EDGE_NONE = 2'd0,
    EDGE_RISE = 2'd1,
    EDGE_FALL = 2'd2
  } edge_code_t;

  typedef enum logic [1:0] {
    HOLD_NONE = 2'd0,
    HOLD_HIGH = 2'd1,
    HOLD_LOW  = 2'd2
  } hold_code_t;

  typedef enum logic [2:0] {
    REG_RISE_HIT  = 3'd0,
    REG_RISE_HOLD = 3'd1,
    REG_FALL_HIT  = 3'd2,
    REG_FALL_HOLD = 3'd3,
    REG_HIGH_LIM  = 3'd4,
    REG_LOW_LIM   = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic                 rise_hit_enable;
    logic                 rise_hold_enable;
    logic                 fall_hit_enable;
    logic                 fall_hold_enable;
    logic [TimeWidth-1:0] high_hold_limit;
    logic [TimeWidth-1:0] low_hold_limit;
  } cfg_t;

  typedef struct packed {
    edge_code_t edge_event;
    hold_code_t hold_event;
  } result_t;

endpackage

>>> rtl/pehd_core.sv
// Detector core: level history, hold timer state and the result logic.
// Depends on pehd_pkg for the configuration and result types.
// The state advances at each accepted request; the result is combinational.
module pehd_core #(
  parameter int unsigned TIME_W = pehd_pkg::TimeWidth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              pin_level,
  input  logic [TIME_W-1:0] elapsed,
  input  pehd_pkg::cfg_t    cfg,
  output pehd_pkg::result_t result
);

  logic              last_level_r, last_level_nxt;
  logic              timing_active_r, timing_active_nxt;
  logic [TIME_W-1:0] hold_count_r, hold_count_nxt;

  logic              tick;
  logic              level_change;
  logic              armed;
  logic [TIME_W-1:0] base_count;
  logic [TIME_W:0]   sum_wide;
  logic [TIME_W-1:0] sum_sat;
  logic [TIME_W-1:0] limit;

  assign tick         = (elapsed != '0);
  assign level_change = (last_level_r != pin_level);
  assign limit        = pin_level ? TIME_W'(cfg.high_hold_limit)
                                  : TIME_W'(cfg.low_hold_limit);
  assign sum_wide     = {1'b0, base_count} + {1'b0, elapsed};
  assign sum_sat      = sum_wide[TIME_W] ? {TIME_W{1'b1}} : sum_wide[TIME_W-1:0];

  always_comb begin
    last_level_nxt    = last_level_r;
    timing_active_nxt = timing_active_r;
    hold_count_nxt    = hold_count_r;
    result.edge_event = pehd_pkg::EDGE_NONE;
    result.hold_event = pehd_pkg::HOLD_NONE;
    armed             = timing_active_r;
    base_count        = hold_count_r;

    if (tick) begin
      last_level_nxt = pin_level;
      if (level_change) begin
        base_count = '0;
        if (pin_level) begin
          armed = cfg.rise_hold_enable;
          if (cfg.rise_hit_enable) result.edge_event = pehd_pkg::EDGE_RISE;
        end else begin
          armed = cfg.fall_hold_enable;
          if (cfg.fall_hit_enable) result.edge_event = pehd_pkg::EDGE_FALL;
        end
      end
      timing_active_nxt = armed;
      hold_count_nxt    = base_count;
      if (armed) begin
        // The edge tick itself already counts toward the hold time.
        if (sum_sat > limit) begin
          timing_active_nxt = 1'b0;
          hold_count_nxt    = '0;
          result.hold_event = pin_level ? pehd_pkg::HOLD_HIGH : pehd_pkg::HOLD_LOW;
        end else begin
          hold_count_nxt = sum_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r    <= 1'b0;
      timing_active_r <= 1'b0;
      hold_count_r    <= '0;
    end else if (accept) begin
      last_level_r    <= last_level_nxt;
      timing_active_r <= timing_active_nxt;
      hold_count_r    <= hold_count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !timing_active_r |-> (hold_count_r == '0))
    else $error("hold count nonzero while timing is off");

  a_zero_tick_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (elapsed == '0)) |=>
      ($stable(last_level_r) && $stable(timing_active_r) && $stable(hold_count_r)))
    else $error("zero elapsed tick changed state");

  a_hold_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (result.hold_event != pehd_pkg::HOLD_NONE)) |=>
      (!timing_active_r && (hold_count_r == '0)))
    else $error("hold event did not disarm the timer");
`endif

endmodule

>>> rtl/pin_edge_and_hold_detector_unit.sv
// Top level of the pin edge and hold detector.
// Depends on pehd_pkg and pehd_core; holds the register file, APB port
// and the two-entry result buffer.
//
// Usage:
//   Input channel (in_valid / in_stall): one request per sample tick with
//   the pin level and the time elapsed since the previous tick. A tick with
//   zero elapsed time leaves the state alone and yields an empty result.
//   Result channel (out_valid / out_stall): exactly one result per request,
//   with edge_event and hold_event, in request order.
//   Results are registered; one request can be accepted every cycle while
//   in_stall is low. The result register plus a one-entry skid register
//   let a request enter while a finished result still waits; in_stall is
//   a register output that rises only once both entries are occupied.
//   Configuration is written through the APB port (register i at byte
//   address 4*i) by the user only while no request is in flight; the
//   block does not enforce this. Reset (rst_n low, synchronous) clears the
//   level history, the hold timer, all registers and both result entries.
module pin_edge_and_hold_detector_unit #(
  parameter int unsigned TIME_W = pehd_pkg::TimeWidth
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_pin_level,
  input  logic [TIME_W-1:0]              in_elapsed,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_edge_event,
  output logic [1:0]                     out_hold_event,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pehd_pkg::AddrWidth-1:0] paddr,
  input  logic [pehd_pkg::DataWidth-1:0] pwdata,
  output logic [pehd_pkg::DataWidth-1:0] prdata,
  output logic                           pready
);

  pehd_pkg::cfg_t    cfg_r;
  pehd_pkg::result_t core_result;
  pehd_pkg::result_t out_data_r, skid_data_r;
  logic              out_valid_r, skid_valid_r;
  logic              in_accept;
  logic              out_take;
  logic              cfg_write;
  logic [2:0]        reg_sel;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = paddr[pehd_pkg::AddrWidth-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        pehd_pkg::REG_RISE_HIT:  cfg_r.rise_hit_enable  <= pwdata[0];
        pehd_pkg::REG_RISE_HOLD: cfg_r.rise_hold_enable <= pwdata[0];
        pehd_pkg::REG_FALL_HIT:  cfg_r.fall_hit_enable  <= pwdata[0];
        pehd_pkg::REG_FALL_HOLD: cfg_r.fall_hold_enable <= pwdata[0];
        pehd_pkg::REG_HIGH_LIM:  cfg_r.high_hold_limit  <= pwdata[pehd_pkg::TimeWidth-1:0];
        pehd_pkg::REG_LOW_LIM:   cfg_r.low_hold_limit   <= pwdata[pehd_pkg::TimeWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      pehd_pkg::REG_RISE_HIT:  prdata[0] = cfg_r.rise_hit_enable;
      pehd_pkg::REG_RISE_HOLD: prdata[0] = cfg_r.rise_hold_enable;
      pehd_pkg::REG_FALL_HIT:  prdata[0] = cfg_r.fall_hit_enable;
      pehd_pkg::REG_FALL_HOLD: prdata[0] = cfg_r.fall_hold_enable;
      pehd_pkg::REG_HIGH_LIM:  prdata[pehd_pkg::TimeWidth-1:0] = cfg_r.high_hold_limit;
      pehd_pkg::REG_LOW_LIM:   prdata[pehd_pkg::TimeWidth-1:0] = cfg_r.low_hold_limit;
      default: ;
    endcase
  end

  pehd_core #(
    .TIME_W (TIME_W)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .pin_level (in_pin_level),
    .elapsed   (in_elapsed),
    .cfg       (cfg_r),
    .result    (core_result)
  );

  // Result buffer: the skid entry fills only when a request arrives while the
  // output entry is held, and drains into the output entry once it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_take) begin
        out_valid_r  <= skid_valid_r || in_accept;
        skid_valid_r <= 1'b0;
      end else if (in_accept) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_data_r <= skid_valid_r ? skid_data_r : core_result;
    end
    if (in_accept && out_valid_r && !out_take) begin
      skid_data_r <= core_result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_edge_event = out_data_r.edge_event;
  assign out_hold_event = out_data_r.hold_event;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry occupied while output entry empty");

  a_skid_fills_on_block: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && out_valid_r && out_stall) |=> skid_valid_r)
    else $error("request under a held result was not buffered");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_take) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry did not move to the output entry");
`endif

endmodule
